// File: sv/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb_pkg
// Shared types, constants and arithmetic helpers of the basis builder.
// ----------------------------------------------------------------------------
package obb_pkg;

	localparam int FRAC_BITS      = 16;
	localparam int WORD_BITS      = 32;
	localparam int PROD_BITS      = 64;
	localparam int LEN_BITS       = PROD_BITS / 2;
	localparam int SQRT_STEPS     = PROD_BITS / 2;
	localparam int SQRT_PER_STAGE = 4;
	localparam int SQRT_STAGES    = (SQRT_STEPS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;
	localparam int DIV_STEPS      = 2 * FRAC_BITS + 1;
	localparam int DIV_PER_STAGE  = 4;
	localparam int DIV_STAGES     = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

	localparam logic signed [PROD_BITS-1:0] WMAX =
		(PROD_BITS'(1) <<< (WORD_BITS - 1)) - PROD_BITS'(1);
	localparam logic signed [PROD_BITS-1:0] WMIN = -WMAX - PROD_BITS'(1);

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef word_t [2:0] vec_t;   // index 0 = x

	typedef struct packed {
		word_t in_a_x;
		word_t in_a_y;
		word_t in_a_z;
		word_t in_b_x;
		word_t in_b_y;
		word_t in_b_z;
	} in_word_t;

	typedef struct packed {
		word_t out_a_x;
		word_t out_a_y;
		word_t out_a_z;
		word_t out_b_x;
		word_t out_b_y;
		word_t out_b_z;
		word_t out_c_x;
		word_t out_c_y;
		word_t out_c_z;
		logic  degenerate;
	} out_word_t;

	// magnitude as unsigned; -2^(W-1) maps to 2^(W-1)
	function automatic logic [WORD_BITS-1:0] mag(word_t w);
		return w[WORD_BITS-1] ? WORD_BITS'(-w) : WORD_BITS'(w);
	endfunction

	function automatic word_t sat64(logic signed [PROD_BITS-1:0] x);
		if (x > WMAX)
			return word_t'(WMAX);
		if (x < WMIN)
			return word_t'(WMIN);
		return x[WORD_BITS-1:0];
	endfunction

	// (p - q) >>> F, wrapping difference, then clamp
	function automatic word_t cross_fin(logic signed [PROD_BITS-1:0] p,
		logic signed [PROD_BITS-1:0] q);
		logic signed [PROD_BITS-1:0] d;
		d = p - q;
		return sat64(d >>> FRAC_BITS);
	endfunction

	function automatic int nxt(int k);
		return (k == 2) ? 0 : k + 1;
	endfunction

endpackage

// File: sv/obb_norm.sv
// ----------------------------------------------------------------------------
// obb_norm
// Pipelined vector normalize: sum of squares, bitwise square root,
// restoring reciprocal, scale. Zero-length vectors pass unchanged.
// ----------------------------------------------------------------------------
module obb_norm #(
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  obb_pkg::vec_t       in_vec,
	input  logic [SIDE_W-1:0]   in_side,
	output logic                out_valid,
	output obb_pkg::vec_t       out_vec,
	output logic [SIDE_W-1:0]   out_side
);

	typedef struct packed {
		obb_pkg::vec_t       vec;
		logic [SIDE_W-1:0]   side;
	} carry_t;

	// squares
	logic                              v_s1;
	carry_t                            c_s1;
	logic [obb_pkg::PROD_BITS-1:0]     sq_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= '{vec: in_vec, side: in_side};
			for (int k = 0; k < 3; k++)
				sq_s1[k] <= obb_pkg::PROD_BITS'(obb_pkg::mag(in_vec[k])) *
					obb_pkg::PROD_BITS'(obb_pkg::mag(in_vec[k]));
		end
	end

	// square root pipeline, entry 0 holds the sum
	logic                              sqv_s [obb_pkg::SQRT_STAGES+1];
	carry_t                            sqc_s [obb_pkg::SQRT_STAGES+1];
	logic [obb_pkg::PROD_BITS-1:0]     sqn_s [obb_pkg::SQRT_STAGES+1];
	logic [obb_pkg::PROD_BITS-1:0]     sqr_s [obb_pkg::SQRT_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sqv_s[0] <= 1'b0;
		else if (en)
			sqv_s[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqc_s[0] <= c_s1;
			sqn_s[0] <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			sqr_s[0] <= '0;
		end
	end

	for (genvar g = 0; g < obb_pkg::SQRT_STAGES; g++) begin : g_sqrt
		logic [obb_pkg::PROD_BITS-1:0] n_c, r_c, b_c;

		always_comb begin
			n_c = sqn_s[g];
			r_c = sqr_s[g];
			b_c = '0;
			for (int k = 0; k < obb_pkg::SQRT_PER_STAGE; k++) begin
				if (g * obb_pkg::SQRT_PER_STAGE + k < obb_pkg::SQRT_STEPS) begin
					b_c = obb_pkg::PROD_BITS'(1) <<
						(obb_pkg::PROD_BITS - 2 - 2 * (g * obb_pkg::SQRT_PER_STAGE + k));
					if (n_c >= r_c + b_c) begin
						n_c = n_c - (r_c + b_c);
						r_c = (r_c >> 1) + b_c;
					end else begin
						r_c = r_c >> 1;
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sqv_s[g+1] <= 1'b0;
			else if (en)
				sqv_s[g+1] <= sqv_s[g];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sqc_s[g+1] <= sqc_s[g];
				sqn_s[g+1] <= n_c;
				sqr_s[g+1] <= r_c;
			end
		end
	end

	// reciprocal 2^(2F) / len, restoring division
	logic                                dv_s [obb_pkg::DIV_STAGES];
	carry_t                              dc_s [obb_pkg::DIV_STAGES];
	logic [obb_pkg::LEN_BITS-1:0]        dd_s [obb_pkg::DIV_STAGES];
	logic [obb_pkg::LEN_BITS-1:0]        dr_s [obb_pkg::DIV_STAGES];
	logic [obb_pkg::DIV_STEPS-1:0]       dq_s [obb_pkg::DIV_STAGES];

	for (genvar g = 0; g < obb_pkg::DIV_STAGES; g++) begin : g_div
		logic                            v_i;
		carry_t                          c_i;
		logic [obb_pkg::LEN_BITS-1:0]    d_i, r_i;
		logic [obb_pkg::DIV_STEPS-1:0]   q_i;
		logic [obb_pkg::LEN_BITS:0]      t_c;
		logic [obb_pkg::LEN_BITS-1:0]    r_c;
		logic [obb_pkg::DIV_STEPS-1:0]   q_c;

		if (g == 0) begin : g_first
			assign v_i = sqv_s[obb_pkg::SQRT_STAGES];
			assign c_i = sqc_s[obb_pkg::SQRT_STAGES];
			assign d_i = sqr_s[obb_pkg::SQRT_STAGES][obb_pkg::LEN_BITS-1:0];
			assign r_i = '0;
			assign q_i = '0;
		end else begin : g_rest
			assign v_i = dv_s[g-1];
			assign c_i = dc_s[g-1];
			assign d_i = dd_s[g-1];
			assign r_i = dr_s[g-1];
			assign q_i = dq_s[g-1];
		end

		always_comb begin
			r_c = r_i;
			q_c = q_i;
			t_c = '0;
			for (int k = 0; k < obb_pkg::DIV_PER_STAGE; k++) begin
				if (g * obb_pkg::DIV_PER_STAGE + k < obb_pkg::DIV_STEPS) begin
					// numerator has a single one in its top bit
					t_c = {r_c, (g == 0 && k == 0) ? 1'b1 : 1'b0};
					if (t_c >= {1'b0, d_i}) begin
						t_c = t_c - {1'b0, d_i};
						q_c = {q_c[obb_pkg::DIV_STEPS-2:0], 1'b1};
					end else begin
						q_c = {q_c[obb_pkg::DIV_STEPS-2:0], 1'b0};
					end
					r_c = t_c[obb_pkg::LEN_BITS-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_s[g] <= 1'b0;
			else if (en)
				dv_s[g] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dc_s[g] <= c_i;
				dd_s[g] <= d_i;
				dr_s[g] <= r_c;
				dq_s[g] <= q_c;
			end
		end
	end

	// scale by reciprocal
	logic                            mv_s;
	carry_t                          mc_s;
	logic                            mz_s;
	logic [obb_pkg::PROD_BITS-1:0]   mp_s [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mv_s <= 1'b0;
		else if (en)
			mv_s <= dv_s[obb_pkg::DIV_STAGES-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mc_s <= dc_s[obb_pkg::DIV_STAGES-1];
			mz_s <= (dd_s[obb_pkg::DIV_STAGES-1] == '0);
			for (int k = 0; k < 3; k++)
				mp_s[k] <= obb_pkg::PROD_BITS'(
					obb_pkg::PROD_BITS'(obb_pkg::mag(dc_s[obb_pkg::DIV_STAGES-1].vec[k])) *
					obb_pkg::PROD_BITS'(dq_s[obb_pkg::DIV_STAGES-1]));
		end
	end

	// truncate, restore sign, clamp
	obb_pkg::vec_t vec_c;

	always_comb begin
		logic signed [obb_pkg::PROD_BITS-1:0] s;
		for (int k = 0; k < 3; k++) begin
			s = $signed(mp_s[k] >> obb_pkg::FRAC_BITS);
			if (mc_s.vec[k][obb_pkg::WORD_BITS-1])
				s = -s;
			vec_c[k] = mz_s ? mc_s.vec[k] : obb_pkg::sat64(s);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= mv_s;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_vec  <= vec_c;
			out_side <= mc_s.side;
		end
	end

endmodule

// File: sv/orthonormal_basis_builder_unit.sv
// ----------------------------------------------------------------------------
// orthonormal_basis_builder_unit
// Builds an orthonormal basis from two Q16.16 vectors a and b.
// ----------------------------------------------------------------------------
// One word enters per clock and one result word leaves per clock unless the
// output stalls. It holds two 21-stage normalize pipelines, each with a
// 4-bit-per-stage square root and reciprocal, and two 2-stage cross-product
// sections. The whole pipeline advances together and freezes only while a
// result sits at the output with dst_stall high, so src_stall is exactly
// that condition. Output a is a normalized (unchanged if zero length), c is
// the normalized a x b, and b is c x a. When a x b truncates to exactly zero,
// degenerate is set, b is returned as given and c is zero. All arithmetic
// truncates; cross products saturate to 32 bits.
// ----------------------------------------------------------------------------
module orthonormal_basis_builder_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  obb_pkg::in_word_t  src_word,
	output logic               dst_valid,
	input  logic               dst_stall,
	output obb_pkg::out_word_t dst_word
);

	typedef struct packed {
		obb_pkg::vec_t a;
		obb_pkg::vec_t b;
		logic          degen;
	} side_c_t;

	localparam int SIDE_A_W = $bits(obb_pkg::vec_t);
	localparam int SIDE_C_W = $bits(side_c_t);

	// global advance: hold everything while the output word is stalled
	logic en;
	assign en        = !(dst_valid && dst_stall);
	assign src_stall = !en;

	// normalize a, carrying b alongside
	obb_pkg::vec_t         a_in, b_in;
	logic                  na_valid;
	obb_pkg::vec_t         na_vec;
	logic [SIDE_A_W-1:0]   na_side;

	assign a_in = {src_word.in_a_z, src_word.in_a_y, src_word.in_a_x};
	assign b_in = {src_word.in_b_z, src_word.in_b_y, src_word.in_b_x};

	obb_norm #(.SIDE_W(SIDE_A_W)) u_norm_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (src_valid),
		.in_vec    (a_in),
		.in_side   (b_in),
		.out_valid (na_valid),
		.out_vec   (na_vec),
		.out_side  (na_side)
	);

	// c = a x b: products
	logic                                   x1_v;
	obb_pkg::vec_t                          x1_a, x1_b;
	logic signed [obb_pkg::PROD_BITS-1:0]   x1_p [3];
	logic signed [obb_pkg::PROD_BITS-1:0]   x1_q [3];
	obb_pkg::vec_t                          nb_vec;

	assign nb_vec = obb_pkg::vec_t'(na_side);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			x1_v <= 1'b0;
		else if (en)
			x1_v <= na_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_a <= na_vec;
			x1_b <= nb_vec;
			for (int k = 0; k < 3; k++) begin
				x1_p[k] <= obb_pkg::PROD_BITS'($signed(na_vec[obb_pkg::nxt(k)])) *
					obb_pkg::PROD_BITS'($signed(nb_vec[obb_pkg::nxt(obb_pkg::nxt(k))]));
				x1_q[k] <= obb_pkg::PROD_BITS'($signed(na_vec[obb_pkg::nxt(obb_pkg::nxt(k))])) *
					obb_pkg::PROD_BITS'($signed(nb_vec[obb_pkg::nxt(k)]));
			end
		end
	end

	// c = a x b: difference, shift, clamp, zero test
	logic            x2_v;
	obb_pkg::vec_t   x2_c, c_c;
	side_c_t         x2_side;

	always_comb begin
		for (int k = 0; k < 3; k++)
			c_c[k] = obb_pkg::cross_fin(x1_p[k], x1_q[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			x2_v <= 1'b0;
		else if (en)
			x2_v <= x1_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x2_c    <= c_c;
			x2_side <= '{a: x1_a, b: x1_b, degen: (c_c == '0)};
		end
	end

	// normalize c; a zero c passes through as zero
	logic                  nc_valid;
	obb_pkg::vec_t         nc_vec;
	logic [SIDE_C_W-1:0]   nc_side_bits;
	side_c_t               nc_side;

	obb_norm #(.SIDE_W(SIDE_C_W)) u_norm_c (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (x2_v),
		.in_vec    (x2_c),
		.in_side   (x2_side),
		.out_valid (nc_valid),
		.out_vec   (nc_vec),
		.out_side  (nc_side_bits)
	);

	assign nc_side = side_c_t'(nc_side_bits);

	// b' = c x a: products
	logic                                   y1_v;
	obb_pkg::vec_t                          y1_c;
	side_c_t                                y1_side;
	logic signed [obb_pkg::PROD_BITS-1:0]   y1_p [3];
	logic signed [obb_pkg::PROD_BITS-1:0]   y1_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			y1_v <= 1'b0;
		else if (en)
			y1_v <= nc_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y1_c    <= nc_vec;
			y1_side <= nc_side;
			for (int k = 0; k < 3; k++) begin
				y1_p[k] <= obb_pkg::PROD_BITS'($signed(nc_vec[obb_pkg::nxt(k)])) *
					obb_pkg::PROD_BITS'($signed(nc_side.a[obb_pkg::nxt(obb_pkg::nxt(k))]));
				y1_q[k] <= obb_pkg::PROD_BITS'($signed(nc_vec[obb_pkg::nxt(obb_pkg::nxt(k))])) *
					obb_pkg::PROD_BITS'($signed(nc_side.a[obb_pkg::nxt(k)]));
			end
		end
	end

	// output register; degenerate pairs keep the original b
	obb_pkg::vec_t b_c;

	always_comb begin
		for (int k = 0; k < 3; k++)
			b_c[k] = y1_side.degen ? y1_side.b[k] : obb_pkg::cross_fin(y1_p[k], y1_q[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dst_valid <= 1'b0;
		else if (en)
			dst_valid <= y1_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dst_word.out_a_x    <= y1_side.a[0];
			dst_word.out_a_y    <= y1_side.a[1];
			dst_word.out_a_z    <= y1_side.a[2];
			dst_word.out_b_x    <= b_c[0];
			dst_word.out_b_y    <= b_c[1];
			dst_word.out_b_z    <= b_c[2];
			dst_word.out_c_x    <= y1_c[0];
			dst_word.out_c_y    <= y1_c[1];
			dst_word.out_c_z    <= y1_c[2];
			dst_word.degenerate <= y1_side.degen;
		end
	end

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the orthonormal basis builder.
// ----------------------------------------------------------------------------
// A short table of directed vector pairs runs first. A few rows carry a
// typed-in result. The rest, and about 1350 random pairs after them, are
// checked against a bit-exact model of the fixed-point math kept here. Both
// the source gaps and the output stalls are random.
// ----------------------------------------------------------------------------
module tb_top;

	typedef bit [63:0] q64_t;      // 64-bit two's complement, wraps like the hw
	typedef q64_t trip_t [3];

	typedef struct {
		obb_pkg::in_word_t  w;
		bit                 typed;          // result typed in below
		obb_pkg::out_word_t res;
	} row_t;

	localparam longint ONE        = 64'sd65536;
	localparam longint WORD_HI    = 64'sd2147483647;
	localparam longint WORD_LO    = -64'sd2147483648;
	localparam int     LIMIT      = 600000;
	localparam int     N_RANDOM   = 1350;
	localparam int     DRAIN_WAIT = 80;   // exceeds the pipeline latency

	logic                clk;
	logic                arst_n;
	logic                src_valid;
	logic                src_stall;
	obb_pkg::in_word_t   src_word;
	logic                dst_valid;
	logic                dst_stall = 1'b0;
	obb_pkg::out_word_t  dst_word;

	obb_pkg::out_word_t  basis_q[$];        // predicted basis words, oldest first
	int                  n_mismatch = 0;
	int                  n_cycles = 0;
	int                  stall_mode = 0;

	orthonormal_basis_builder_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_word (src_word),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_word (dst_word)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------- model
	function automatic bit is_neg(q64_t v);
		return v[63];
	endfunction

	function automatic q64_t abs64(q64_t v);
		return is_neg(v) ? 64'd0 - v : v;
	endfunction

	function automatic q64_t clamp_word(q64_t v);
		if ($signed(v) > WORD_HI)
			return q64_t'(WORD_HI);
		if ($signed(v) < WORD_LO)
			return q64_t'(WORD_LO);
		return v;
	endfunction

	// bitwise square root, 32 steps, truncating
	function automatic q64_t root_floor(q64_t n);
		q64_t res;
		q64_t bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (n >= res + bitv) begin
				n   = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic trip_t unit_vec(trip_t v);
		q64_t  s;
		q64_t  len;
		q64_t  r;
		q64_t  m;
		trip_t o;
		s = 0;
		for (int i = 0; i < 3; i++)
			s = s + abs64(v[i]) * abs64(v[i]);   // wraps mod 2^64
		len = root_floor(s);
		if (len == 0)
			return v;                            // zero length passes through
		r = (64'd1 << (2 * obb_pkg::FRAC_BITS)) / len;
		for (int i = 0; i < 3; i++) begin
			m    = (abs64(v[i]) * r) >> obb_pkg::FRAC_BITS;
			o[i] = clamp_word(is_neg(v[i]) ? 64'd0 - m : m);
		end
		return o;
	endfunction

	function automatic q64_t cross_term(q64_t p1, q64_t p2, q64_t q1, q64_t q2);
		q64_t d;
		d = p1 * p2 - q1 * q2;
		return clamp_word(q64_t'($signed(d) >>> obb_pkg::FRAC_BITS));
	endfunction

	function automatic trip_t cross3(trip_t u, trip_t v);
		trip_t w;
		w[0] = cross_term(u[1], v[2], u[2], v[1]);
		w[1] = cross_term(u[2], v[0], u[0], v[2]);
		w[2] = cross_term(u[0], v[1], u[1], v[0]);
		return w;
	endfunction

	function automatic obb_pkg::out_word_t build_basis(obb_pkg::in_word_t w);
		trip_t              a, b, c;
		bit                 degen;
		obb_pkg::out_word_t o;
		a[0] = q64_t'(longint'(w.in_a_x));
		a[1] = q64_t'(longint'(w.in_a_y));
		a[2] = q64_t'(longint'(w.in_a_z));
		b[0] = q64_t'(longint'(w.in_b_x));
		b[1] = q64_t'(longint'(w.in_b_y));
		b[2] = q64_t'(longint'(w.in_b_z));
		a     = unit_vec(a);
		c     = cross3(a, b);
		degen = (c[0] == 0) && (c[1] == 0) && (c[2] == 0);
		if (!degen) begin
			c = unit_vec(c);
			b = cross3(c, a);
		end
		o.out_a_x    = a[0][31:0];
		o.out_a_y    = a[1][31:0];
		o.out_a_z    = a[2][31:0];
		o.out_b_x    = b[0][31:0];
		o.out_b_y    = b[1][31:0];
		o.out_b_z    = b[2][31:0];
		o.out_c_x    = c[0][31:0];
		o.out_c_y    = c[1][31:0];
		o.out_c_z    = c[2][31:0];
		o.degenerate = degen;
		return o;
	endfunction

	// ------------------------------------------------------------ helpers
	function automatic obb_pkg::in_word_t pair(int ax, int ay, int az, int bx, int by, int bz);
		obb_pkg::in_word_t w;
		w.in_a_x = ax;
		w.in_a_y = ay;
		w.in_a_z = az;
		w.in_b_x = bx;
		w.in_b_y = by;
		w.in_b_z = bz;
		return w;
	endfunction

	function automatic int rand_word();
		return int'($urandom);
	endfunction

	// small Q16.16 value, about +-8.0
	function automatic int rand_small();
		return int'($urandom_range(0, 1048576)) - 524288;
	endfunction

	// pick from the corners of the range
	function automatic int rand_corner();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 0;
			3: return 1;
			4: return -1;
			default: return int'(ONE);
		endcase
	endfunction

	function automatic obb_pkg::in_word_t rand_pair();
		obb_pkg::in_word_t w;
		int                k;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				w = pair(rand_word(), rand_word(), rand_word(),
					rand_word(), rand_word(), rand_word());
			end
			3, 4, 5: begin
				w = pair(rand_small(), rand_small(), rand_small(),
					rand_small(), rand_small(), rand_small());
			end
			6: begin
				// b a whole multiple of a (parallel, or zero)
				k = $urandom_range(0, 6) - 3;
				w = pair(rand_small(), rand_small(), rand_small(), 0, 0, 0);
				w.in_b_x = w.in_a_x * k;
				w.in_b_y = w.in_a_y * k;
				w.in_b_z = w.in_a_z * k;
			end
			7: begin
				// zero a, anything for b
				w = pair(0, 0, 0, rand_word(), rand_word(), rand_word());
			end
			8: begin
				w = pair(rand_corner(), rand_corner(), rand_corner(),
					rand_corner(), rand_corner(), rand_corner());
			end
			default: begin
				// tiny components: truncation to zero in the cross product
				w = pair($urandom_range(0, 7) - 3, $urandom_range(0, 7) - 3,
					$urandom_range(0, 7) - 3, $urandom_range(0, 7) - 3,
					$urandom_range(0, 7) - 3, $urandom_range(0, 7) - 3);
			end
		endcase
		return w;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int rand_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	task automatic send_word(obb_pkg::in_word_t w);
		int gap;
		src_valid <= 1'b1;
		src_word  <= w;
		do
			@(posedge clk);
		while (src_stall);
		gap = rand_gap();
		if (gap > 0) begin
			src_valid <= 1'b0;
			src_word  <= rand_pair();      // payload is don't-care while idle
			repeat (gap) @(posedge clk);
		end
	endtask

	// ------------------------------------------------------------ scoreboard
	// Push on each accepted input word, pop on each accepted output word.
	// Directed rows with a typed-in result push that instead of the model's.
	bit                 typed_pending;
	obb_pkg::out_word_t typed_res;

	always @(posedge clk) begin
		obb_pkg::out_word_t exp_w;
		bit                 bad;
		if (arst_n) begin
			if (src_valid && !src_stall)
				basis_q.push_back(typed_pending ? typed_res : build_basis(src_word));
			if (dst_valid && !dst_stall) begin
				if (basis_q.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("unexpected basis word %h", dst_word);
				end else begin
					exp_w = basis_q.pop_front();
					bad   = 1'b0;
					// nine 32-bit components, x/y/z of a, b, c, then the flag
					for (int i = 0; i < 9; i++)
						if (dst_word[288 - 32 * i -: 32] !== exp_w[288 - 32 * i -: 32])
							bad = 1'b1;
					if (dst_word.degenerate !== exp_w.degenerate)
						bad = 1'b1;
					if (bad) begin
						n_mismatch++;
						if (n_mismatch <= 10)
							$display("basis mismatch: exp %h got %h", exp_w, dst_word);
					end
				end
			end
		end
	end

	// output stall: phases of none, light and heavy back-pressure
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: dst_stall <= 1'b0;
			1: dst_stall <= ($urandom_range(0, 9) < 2);
			default: dst_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles > LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------ stimulus
	row_t dir_rows[$];

	initial begin
		row_t               r;
		obb_pkg::out_word_t z;
		src_valid     = 1'b0;
		src_word      = '0;
		typed_pending = 1'b0;
		typed_res     = '0;
		arst_n        = 1'b0;

		// typed-in: all zero -> zero a passes, degenerate, everything zero
		z       = '0;
		z.degenerate = 1'b1;
		r.w     = pair(0, 0, 0, 0, 0, 0);
		r.typed = 1'b1;
		r.res   = z;
		dir_rows.push_back(r);
		// typed-in: x and y unit axes give the standard basis
		z       = '0;
		z.out_a_x = int'(ONE);
		z.out_b_y = int'(ONE);
		z.out_c_z = int'(ONE);
		r.w     = pair(int'(ONE), 0, 0, 0, int'(ONE), 0);
		r.res   = z;
		dir_rows.push_back(r);
		// typed-in: zero a with any b is degenerate, b handed back as is
		z       = '0;
		z.out_b_x = 32'sh7fffffff;
		z.out_b_y = 32'sh80000000;
		z.out_b_z = 5;
		z.degenerate = 1'b1;
		r.w     = pair(0, 0, 0, 32'sh7fffffff, 32'sh80000000, 5);
		r.res   = z;
		dir_rows.push_back(r);

		r.typed = 1'b0;
		r.res   = '0;
		r.w = pair(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000);
		dir_rows.push_back(r);
		r.w = pair(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 0, 32'sh80000000);
		dir_rows.push_back(r);
		r.w = pair(32'sh80000000, 0, 0, 0, 32'sh80000000, 0);
		dir_rows.push_back(r);
		r.w = pair(-1, -1, -1, -1, -1, -1);
		dir_rows.push_back(r);
		r.w = pair(1, 0, 0, 0, 1, 0);                          // tiny: a x b comes out as one lsb
		dir_rows.push_back(r);
		r.w = pair(int'(ONE), int'(ONE), 0, 2 * int'(ONE), 2 * int'(ONE), 0);  // parallel
		dir_rows.push_back(r);
		r.w = pair(0, 0, 3 * int'(ONE), 32'sh7fffffff, 32'sh7fffffff, 0);  // cross product near full scale
		dir_rows.push_back(r);
		r.w = pair(32'sh7fffffff, 32'sh80000000, 1, 1, 32'sh7fffffff, 32'sh80000000);
		dir_rows.push_back(r);
		r.w = pair(3 * int'(ONE), -4 * int'(ONE), 12 * int'(ONE),
			-int'(ONE), 5 * int'(ONE), 2 * int'(ONE));
		dir_rows.push_back(r);
		r.w = pair(int'(ONE) / 2, 0, 0, int'(ONE), int'(ONE), int'(ONE));
		dir_rows.push_back(r);
		r.w = pair(32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f,
			32'haaaaaaaa, 32'h55555555, 32'hf0f0f0f0);
		dir_rows.push_back(r);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// typed_pending is sampled on the accepting edge, so it changes with the word
		foreach (dir_rows[i]) begin
			typed_pending <= dir_rows[i].typed;
			typed_res     <= dir_rows[i].res;
			send_word(dir_rows[i].w);
		end
		typed_pending <= 1'b0;
		for (int i = 0; i < N_RANDOM; i++)
			send_word(rand_pair());
		src_valid <= 1'b0;

		while (basis_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (n_mismatch == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
